FILE: rtl/dec_pkg.sv
// Package: shared constants and result struct for the double/extended converter.
package dec_pkg;

    localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
    localparam logic [15:0] EXT_SIGN    = 16'h8000;
    localparam int          EXT_BIAS    = 16383;
    localparam int          DBL_BIAS    = 1023;
    localparam int          EXT_OFFSET  = 16446;
    localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;

    localparam logic REQ_WIDEN  = 1'b0;
    localparam logic REQ_NARROW = 1'b1;

    typedef struct packed {
        logic [63:0] dbl;
        logic [15:0] sign_exp;
        logic [63:0] mantissa;
    } result_t;

    // position of the highest set bit, 0 when none
    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 1; i < 64; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/dec_core.sv
// Combinational conversion between double and 80-bit extended formats.
module dec_core
(
    input  logic              req_type,
    input  logic [63:0]       double_bits,
    input  logic [15:0]       ext_sign_exp,
    input  logic [63:0]       ext_mantissa,
    output dec_pkg::result_t  res
);

    // widen
    logic        w_sign;
    logic [10:0] w_e;
    logic [51:0] w_f;
    logic [5:0]  w_p;
    logic [15:0] w_se;
    logic [63:0] w_m;

    // narrow
    logic        n_sign;
    logic [14:0] n_x;
    logic [5:0]  n_p;
    logic signed [17:0] n_ue;
    logic signed [17:0] n_biased;
    logic signed [17:0] n_q;
    logic signed [17:0] n_sh;
    logic [63:0] n_sig;
    logic [63:0] n_rem;
    logic [63:0] n_half;
    logic [63:0] n_mask;
    logic [6:0]  n_shu;
    logic [63:0] n_bits;

    always_comb
    begin
        w_sign = double_bits[63];
        w_e    = double_bits[62:52];
        w_f    = double_bits[51:0];
        w_p    = dec_pkg::top_bit({12'd0, w_f});
        if (w_e == 11'd0 && w_f == 52'd0)
        begin
            w_se = 16'd0;
            w_m  = 64'd0;
        end
        else if (w_e == 11'h7FF)
        begin
            w_se = (w_f != 52'd0) ? {1'b0, dec_pkg::EXT_EXP_MAX}
                                  : {w_sign, dec_pkg::EXT_EXP_MAX};
            w_m  = 64'd0;
        end
        else if (w_e != 11'd0)
        begin
            w_se = {w_sign, 15'({4'd0, w_e} + 15'(dec_pkg::EXT_BIAS - dec_pkg::DBL_BIAS))};
            w_m  = {1'b1, w_f, 11'd0};
        end
        else
        begin
            w_se = {w_sign, 15'({9'd0, w_p} + 15'(dec_pkg::EXT_BIAS - 1074))};
            w_m  = {12'd0, w_f} << (6'd63 - w_p);
        end
    end

    always_comb
    begin
        n_sign   = ext_sign_exp[15];
        n_x      = ext_sign_exp[14:0];
        n_p      = dec_pkg::top_bit(ext_mantissa);
        n_ue     = 18'sd0 + $signed({12'd0, n_p}) + $signed({3'd0, n_x})
                   - 18'sd16446;
        n_biased = n_ue + 18'sd1023;
        n_q      = (n_biased >= 18'sd1) ? (n_ue - 18'sd52) : -18'sd1074;
        n_sh     = n_q - ($signed({3'd0, n_x}) - 18'sd16446);
        n_shu    = 7'd0;
        n_sig    = 64'd0;
        n_rem    = 64'd0;
        n_half   = 64'd0;
        n_mask   = 64'd0;
        if (n_sh <= 18'sd0)
        begin
            n_sig = ext_mantissa << 7'(-n_sh);
        end
        else if (n_sh >= 18'sd65)
        begin
            n_sig = 64'd0;
        end
        else
        begin
            n_shu  = 7'(n_sh);
            n_sig  = (n_shu == 7'd64) ? 64'd0 : (ext_mantissa >> n_shu);
            n_mask = (n_shu == 7'd64) ? {64{1'b1}} : ((64'd1 << n_shu) - 64'd1);
            n_rem  = ext_mantissa & n_mask;
            n_half = 64'd1 << (n_shu - 7'd1);
            if (n_rem > n_half || (n_rem == n_half && n_sig[0]))
            begin
                n_sig = n_sig + 64'd1;
            end
        end
        if (n_x == dec_pkg::EXT_EXP_MAX)
        begin
            n_bits = {n_sign, 63'd0} | dec_pkg::DBL_INF;
        end
        else if (ext_mantissa == 64'd0)
        begin
            n_bits = {n_sign, 63'd0};
        end
        else if (n_biased >= 18'sd2047)
        begin
            n_bits = {n_sign, 63'd0} | dec_pkg::DBL_INF;
        end
        else if (n_biased >= 18'sd1)
        begin
            // carry out of the significand rolls into the exponent
            n_bits = {n_sign, 63'd0}
                     | (({53'd0, 11'(n_biased - 18'sd1)} << 52) + n_sig);
        end
        else
        begin
            n_bits = {n_sign, 63'd0} | n_sig;
        end
    end

    always_comb
    begin
        if (req_type == dec_pkg::REQ_WIDEN)
        begin
            res.dbl      = 64'd0;
            res.sign_exp = w_se;
            res.mantissa = w_m;
        end
        else
        begin
            res.dbl      = n_bits;
            res.sign_exp = 16'd0;
            res.mantissa = 64'd0;
        end
    end

endmodule

FILE: rtl/double_extended_convert.sv
// Top level: registered double <-> 80-bit extended converter.
// Beats pass the input register, then the result register; a full input
// stage refills while results drain. One beat per cycle while out_stall is low.
// Stall on the input only when both stages hold beats and the output is stalled.
// Reset (rst_n, async, active low) clears both valid flags; payload is not reset.
module double_extended_convert
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] double_bits,
    input  logic [15:0] ext_sign_exp,
    input  logic [63:0] ext_mantissa,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_double_bits,
    output logic [15:0] out_sign_exp,
    output logic [63:0] out_mantissa
);

    logic              a_valid_reg;
    logic              a_type_reg;
    logic [63:0]       a_dbl_reg;
    logic [15:0]       a_se_reg;
    logic [63:0]       a_m_reg;
    logic              b_valid_reg;
    dec_pkg::result_t  b_res_reg;
    dec_pkg::result_t  core_res;
    logic              b_load;
    logic              a_load;

    dec_core u_core
    (
        .req_type     (a_type_reg),
        .double_bits  (a_dbl_reg),
        .ext_sign_exp (a_se_reg),
        .ext_mantissa (a_m_reg),
        .res          (core_res)
    );

    assign b_load   = a_valid_reg && (!b_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !b_load;
    assign a_load   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_type_reg <= req_type;
            a_dbl_reg  <= double_bits;
            a_se_reg   <= ext_sign_exp;
            a_m_reg    <= ext_mantissa;
        end
        if (b_load)
        begin
            b_res_reg <= core_res;
        end
    end

    assign out_valid       = b_valid_reg;
    assign out_double_bits = b_res_reg.dbl;
    assign out_sign_exp    = b_res_reg.sign_exp;
    assign out_mantissa    = b_res_reg.mantissa;

endmodule
